@@ hdl/mbhw_pkg.sv @@
// mbhw_pkg: shared types and constants for the mp4 box header walker
// no dependencies; imported by the cells, response queue, top, checkers and testbench
`default_nettype none
package mbhw_pkg;

   localparam logic [31:0] TYPE_MOOF = 32'h6D6F_6F66;
   localparam logic [31:0] TYPE_TRAF = 32'h7472_6166;
   localparam logic [31:0] HDR_BYTES = 32'd8;
   localparam logic [3:0]  HDR_LAST  = 4'd7;

   localparam int RSP_DEPTH = 4;
   localparam int RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   typedef enum logic [1:0] {
      EV_BOX   = 2'd0,
      EV_SHORT = 2'd1,
      EV_TRUNC = 2'd2
   } event_kind_type;

   typedef struct packed {
      logic [1:0]  event_kind;
      logic [31:0] box_type;
      logic [31:0] box_size;
      logic [2:0]  nest_depth;
      logic        last_result;
   } rsp_type;

   // results written into the response queue in one cycle (0, 1 or 2)
   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } rsp_push_type;

   // per-byte control broadcast to every level cell
   typedef struct packed {
      logic step;
      logic push;
      logic flush;
   } cell_ctrl_type;

endpackage
`default_nettype wire

@@ hdl/mbhw_if.sv @@
// mbhw_req_if / mbhw_rsp_if: valid/ready channels of the box header walker
// depends on nothing
`default_nettype none
interface mbhw_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       end_of_stream;

   modport source (output valid, output data_byte, output end_of_stream, input ready);
   modport sink (input valid, input data_byte, input end_of_stream, output ready);
endinterface

interface mbhw_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  event_kind;
   logic [31:0] box_type;
   logic [31:0] box_size;
   logic [2:0]  nest_depth;
   logic        last_result;

   modport source (output valid, output event_kind, output box_type, output box_size,
                   output nest_depth, output last_result, input ready);
   modport sink (input valid, input event_kind, input box_type, input box_size,
                 input nest_depth, input last_result, output ready);
endinterface
`default_nettype wire

@@ hdl/mp4_box_header_walker.sv @@
// mp4_box_header_walker: byte-serial mp4 box header walker, top level
// depends on mbhw_pkg, mbhw_if, mbhw_level_cell, mbhw_rsp_fifo
//
//  channel | dir | beat contents
//  --------+-----+---------------------------------------------------------
//  req     | in  | data_byte, end_of_stream
//  rsp     | out | event_kind, box_type, box_size, nest_depth, last_result
//
// one byte per cycle: each byte is taken while the result queue has room for two
// results; header capture, skip counter and the row of level cells are combinational
// on each byte, whose results are written into the queue registers and show on rsp
// from there, behind any results still queued.
// reset (synchronous) clears the header counter, skip count, halt flag, open levels
// and the queue. a stalled rsp holds its beat and stops req once the queue lacks room for two.
`default_nettype none
module mp4_box_header_walker
   import mbhw_pkg::*;
#(
   parameter int MAX_DEPTH = 4
) (
   input  wire logic clock,
   input  wire logic reset,
   mbhw_req_if.sink  req,
   mbhw_rsp_if.source rsp
);

   localparam int LVL_W = $clog2(MAX_DEPTH + 1);

   logic [3:0]  hdr_cnt_ff, hdr_cnt_in;
   logic [55:0] hdr_sr_ff, hdr_sr_in;
   logic [31:0] skip_ff, skip_in;
   logic        halted_ff, halted_in;

   logic        acc;
   logic        hdr_done;
   logic [63:0] hdr_word;
   logic [31:0] box_size, box_type, body_len;
   logic        is_short, is_cont, open_new, trunc;

   cell_ctrl_type        cell_ctrl;
   logic [MAX_DEPTH-1:0] open_vec;
   logic [MAX_DEPTH:0]   keep_chain;
   logic [LVL_W-1:0]     depth_now, depth_after;
   logic [LVL_W+2:0]     depth_now_x, depth_after_x;

   rsp_type      box_rsp, trunc_rsp, fifo_out;
   rsp_push_type push;
   logic         room;

   assign keep_chain[MAX_DEPTH] = 1'b0;

   for (genvar i = 0; i < MAX_DEPTH; i++) begin : g_lvl
      mbhw_level_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (cell_ctrl),
         .load_len   (body_len),
         .open_below ((i == 0) ? 1'b1 : open_vec[(i == 0) ? 0 : i - 1]),
         .keep_above (keep_chain[i+1]),
         .is_open    (open_vec[i]),
         .keep_out   (keep_chain[i])
      );
   end

   always_comb begin
      depth_now   = '0;
      depth_after = '0;
      for (int i = 0; i < MAX_DEPTH; i++) begin
         depth_now   = depth_now + LVL_W'(open_vec[i]);
         depth_after = depth_after + LVL_W'(keep_chain[i]);
      end
      depth_now_x   = {3'b000, depth_now};
      depth_after_x = {3'b000, depth_after};
   end

   always_comb begin
      acc      = req.valid && req.ready;
      hdr_word = {hdr_sr_ff, req.data_byte};
      box_size = hdr_word[63:32];
      box_type = hdr_word[31:0];
      body_len = box_size - HDR_BYTES;
      is_short = box_size < HDR_BYTES;
      is_cont  = box_type == TYPE_MOOF || box_type == TYPE_TRAF;
      hdr_done = !halted_ff && skip_ff == 32'd0 && hdr_cnt_ff == HDR_LAST;
      open_new = hdr_done && !is_short && is_cont && !open_vec[MAX_DEPTH-1];

      hdr_cnt_in = hdr_cnt_ff;
      hdr_sr_in  = hdr_sr_ff;
      skip_in    = skip_ff;
      halted_in  = halted_ff;
      if (!halted_ff) begin
         if (skip_ff != 32'd0) begin
            skip_in = skip_ff - 32'd1;
         end else if (hdr_done) begin
            hdr_cnt_in = 4'd0;
            hdr_sr_in  = '0;
            halted_in  = is_short;
            if (!is_short && !open_new) begin
               skip_in = body_len;
            end
         end else begin
            hdr_cnt_in = hdr_cnt_ff + 4'd1;
            hdr_sr_in  = hdr_word[55:0];
         end
      end

      cell_ctrl.step  = acc && !halted_ff;
      cell_ctrl.push  = acc && open_new && body_len != 32'd0;
      cell_ctrl.flush = acc && req.end_of_stream;

      // stream ends with a header, a skip or a level still pending
      trunc = req.end_of_stream && !halted_in &&
              (hdr_cnt_in != 4'd0 || skip_in != 32'd0 || keep_chain[0]);

      box_rsp.event_kind  = is_short ? EV_SHORT : EV_BOX;
      box_rsp.box_type    = box_type;
      box_rsp.box_size    = box_size;
      box_rsp.nest_depth  = depth_now_x[2:0];
      box_rsp.last_result = !trunc;

      trunc_rsp.event_kind  = EV_TRUNC;
      trunc_rsp.box_type    = 32'd0;
      trunc_rsp.box_size    = 32'd0;
      trunc_rsp.nest_depth  = depth_after_x[2:0];
      trunc_rsp.last_result = 1'b1;

      push.first  = hdr_done ? box_rsp : trunc_rsp;
      push.second = trunc_rsp;
      push.count  = acc ? {1'b0, hdr_done} + {1'b0, trunc} : 2'd0;
   end

   always_ff @(posedge clock) begin
      if (reset || (acc && req.end_of_stream)) begin
         hdr_cnt_ff <= 4'd0;
         skip_ff    <= 32'd0;
         halted_ff  <= 1'b0;
      end else if (acc) begin
         hdr_cnt_ff <= hdr_cnt_in;
         skip_ff    <= skip_in;
         halted_ff  <= halted_in;
      end
      if (reset || (acc && req.end_of_stream)) begin
         hdr_sr_ff <= '0;
      end else if (acc) begin
         hdr_sr_ff <= hdr_sr_in;
      end
   end

   mbhw_rsp_fifo u_rsp_fifo (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .room_for_two (room),
      .out_valid    (rsp.valid),
      .out_data     (fifo_out),
      .out_ready    (rsp.ready)
   );

   assign req.ready       = room;
   assign rsp.event_kind  = fifo_out.event_kind;
   assign rsp.box_type    = fifo_out.box_type;
   assign rsp.box_size    = fifo_out.box_size;
   assign rsp.nest_depth  = fifo_out.nest_depth;
   assign rsp.last_result = fifo_out.last_result;

endmodule
`default_nettype wire

@@ hdl/mbhw_level_cell.sv @@
// mbhw_level_cell: one container level, holds the bytes left in that level
// depends on mbhw_pkg; chained from outermost (cell 0) to innermost
`default_nettype none
module mbhw_level_cell
   import mbhw_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire cell_ctrl_type ctrl,
   input  wire logic [31:0]   load_len,
   input  wire logic          open_below,
   input  wire logic          keep_above,
   output logic               is_open,
   output logic               keep_out
);

   logic        open_ff, open_in;
   logic [31:0] rem_ff, rem_in;
   logic [31:0] rem_dec;
   logic        loaded;
   logic        open_p;

   always_comb begin
      rem_dec  = (open_ff && rem_ff != 32'd0) ? rem_ff - 32'd1 : rem_ff;
      // the first closed cell above an open one takes a new level
      loaded   = ctrl.push && !open_ff && open_below;
      rem_in   = loaded ? load_len : rem_dec;
      open_p   = open_ff || loaded;
      // only the innermost level can close, so a level stays while one above it stays
      keep_out = open_p && (rem_in != 32'd0 || keep_above);
      open_in  = keep_out;
   end

   always_ff @(posedge clock) begin
      if (reset || ctrl.flush) begin
         open_ff <= 1'b0;
      end else if (ctrl.step) begin
         open_ff <= open_in;
      end
      if (ctrl.step) begin
         rem_ff <= rem_in;
      end
   end

   assign is_open = open_ff;

endmodule
`default_nettype wire

@@ hdl/mbhw_rsp_fifo.sv @@
// mbhw_rsp_fifo: small result queue, takes up to two results per cycle
// depends on mbhw_pkg
`default_nettype none
module mbhw_rsp_fifo
   import mbhw_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire rsp_push_type push,
   output logic              room_for_two,
   output logic              out_valid,
   output rsp_type           out_data,
   input  wire logic         out_ready
);

   rsp_type              mem_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RSP_PTR_W-1:0] wr_next;
   logic                 pop;

   always_comb begin
      pop       = out_valid && out_ready;
      wr_next   = wr_ptr_ff + RSP_PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
      rd_ptr_in = pop ? rd_ptr_ff + RSP_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (push.count != 2'd0) begin
         mem_ff[wr_ptr_ff] <= push.first;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_next] <= push.second;
      end
   end

   assign out_valid    = cnt_ff != '0;
   assign out_data     = mem_ff[rd_ptr_ff];
   assign room_for_two = cnt_ff <= RSP_CNT_W'(RSP_DEPTH - 2);

endmodule
`default_nettype wire

@@ hdl/mbhw_checker.sv @@
// mbhw_port_checker: port-level assertions for the box header walker, bound to the top
// depends on mbhw_pkg and mp4_box_header_walker
`default_nettype none
module mbhw_port_checker
   import mbhw_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_event_kind,
   input wire logic [31:0] rsp_box_type,
   input wire logic [31:0] rsp_box_size,
   input wire logic        rsp_last_result
);

   // a stalled beat stays valid and keeps its kind, type and size
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_box_type) &&
      $stable(rsp_box_size) && $stable(rsp_event_kind))
      else $error("rsp beat changed while stalled");

   // truncation beats carry no box and always close the byte's results
   a_trunc_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_TRUNC |->
      rsp_last_result && rsp_box_type == 32'd0 && rsp_box_size == 32'd0)
      else $error("truncation beat malformed");

   // the size reported must agree with the kind of event
   a_size_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_kind == EV_BOX || rsp_event_kind == EV_SHORT) |->
      ((rsp_event_kind == EV_SHORT) == (rsp_box_size < 32'd8)))
      else $error("box size does not match event kind");

   // a short-box beat is always the final result of its byte
   a_short_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_event_kind == EV_SHORT |-> rsp_last_result)
      else $error("short box beat not marked last");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind mp4_box_header_walker mbhw_port_checker u_mbhw_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_event_kind  (rsp.event_kind),
   .rsp_box_type    (rsp.box_type),
   .rsp_box_size    (rsp.box_size),
   .rsp_last_result (rsp.last_result)
);
`default_nettype wire

@@ verif/mbhw_checker.sv @@
// mbhw_checker: watches the req and rsp channels of the mp4 box header walker,
// predicts the events of every accepted byte and compares them with the rsp beats
// depends on mbhw_pkg and the interfaces in mbhw_if
module mbhw_checker
   import mbhw_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic clock,
   input  logic reset,
   mbhw_req_if  req,
   mbhw_rsp_if  rsp,
   output int   errors,
   output int   outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   int unsigned hdr_count;
   logic [63:0] hdr_shift;
   logic [31:0] bytes_left [DEPTH];
   int unsigned open_levels;
   logic [31:0] skip_left;
   logic        halted;
   rsp_type     expected_events [$];

   function automatic void clear_walk();
      hdr_count = 0;
      hdr_shift = '0;
      for (int i = 0; i < DEPTH; i++) bytes_left[i] = '0;
      open_levels = 0;
      skip_left = '0;
      halted = 1'b0;
   endfunction

   function automatic rsp_type make_event(input event_kind_type kind, input logic [31:0] btype,
                                          input logic [31:0] bsize, input int unsigned depth);
      rsp_type e;
      e.event_kind = kind;
      e.box_type = btype;
      e.box_size = bsize;
      e.nest_depth = 3'(depth);
      e.last_result = 1'b0;
      return e;
   endfunction

   // one byte through the walker: header capture, skip, level counts, end of stream
   function automatic void walk_byte(input logic [7:0] data, input logic eos);
      rsp_type     found [2];
      int          n_found;
      logic [31:0] bsize;
      logic [31:0] btype;
      logic [31:0] new_len;
      logic        open_new;
      n_found = 0;
      open_new = 1'b0;
      new_len = '0;
      if (halted) begin
         if (eos) clear_walk();
         return;
      end
      if (skip_left != 0) begin
         skip_left--;
      end else begin
         hdr_shift = {hdr_shift[55:0], data};
         hdr_count++;
         if (hdr_count == HDR_BYTES) begin
            bsize = hdr_shift[63:32];
            btype = hdr_shift[31:0];
            hdr_count = 0;
            hdr_shift = '0;
            if (bsize < HDR_BYTES) begin
               found[0] = make_event(EV_SHORT, btype, bsize, open_levels);
               n_found = 1;
               halted = 1'b1;
            end else begin
               found[0] = make_event(EV_BOX, btype, bsize, open_levels);
               n_found = 1;
               if ((btype == TYPE_MOOF || btype == TYPE_TRAF) && open_levels < DEPTH) begin
                  open_new = 1'b1;
                  new_len = bsize - HDR_BYTES;
               end else begin
                  skip_left = bsize - HDR_BYTES;
               end
            end
         end
      end
      // every consumed byte counts against every open level, floored at zero
      for (int i = 0; i < DEPTH; i++) begin
         if (i < open_levels && bytes_left[i] != 0) bytes_left[i]--;
      end
      if (halted) begin
         if (eos) clear_walk();
      end else begin
         if (open_new && new_len != 0) begin
            bytes_left[open_levels] = new_len;
            open_levels++;
         end
         while (open_levels != 0 && bytes_left[open_levels - 1] == 0) open_levels--;
         if (eos) begin
            if (hdr_count != 0 || skip_left != 0 || open_levels != 0) begin
               found[n_found] = make_event(EV_TRUNC, '0, '0, open_levels);
               n_found++;
            end
            clear_walk();
         end
      end
      if (n_found != 0) found[n_found - 1].last_result = 1'b1;
      for (int i = 0; i < n_found; i++) expected_events.push_back(found[i]);
   endfunction

   function automatic void check_event();
      rsp_type want;
      if (expected_events.size() == 0) begin
         errors++;
         if (errors <= 10)
            $display("tb: rsp beat with nothing expected: kind %0d type %h size %h depth %0d last %0d",
                     rsp.event_kind, rsp.box_type, rsp.box_size, rsp.nest_depth,
                     rsp.last_result);
         return;
      end
      want = expected_events.pop_front();
      if (rsp.event_kind !== want.event_kind || rsp.box_type !== want.box_type ||
          rsp.box_size !== want.box_size || rsp.nest_depth !== want.nest_depth ||
          rsp.last_result !== want.last_result) begin
         errors++;
         if (errors <= 10)
            $display({"tb: rsp mismatch: expected kind %0d type %h size %h depth %0d last %0d,",
                      " got kind %0d type %h size %h depth %0d last %0d"},
                     want.event_kind, want.box_type, want.box_size, want.nest_depth,
                     want.last_result, rsp.event_kind, rsp.box_type, rsp.box_size,
                     rsp.nest_depth, rsp.last_result);
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_walk();
         expected_events.delete();
         errors = 0;
      end else begin
         // a result is registered in the queue before it shows on rsp, so the order of these two is free
         if (rsp.valid && rsp.ready) check_event();
         if (req.valid && req.ready) walk_byte(req.data_byte, req.end_of_stream);
      end
      outstanding = expected_events.size();
   end

endmodule

@@ verif/tb.sv @@
// tb: top of the mp4 box header walker testbench; builds byte streams of boxes
// (well formed, nested, truncated, short and noisy), drives req, stalls rsp, gives the verdict
// depends on mbhw_pkg, mbhw_if, mp4_box_header_walker and mbhw_checker
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mbhw_pkg::*;

   localparam int DEPTH = 4;
   localparam int RANDOM_BYTES = 120;
   localparam int QUIET_BYTES = 120;
   localparam int HOLD_CYCLES = 80;
   localparam logic [31:0] TYPE_FREE = 32'h6672_6565;
   localparam logic [31:0] TYPE_MDAT = 32'h6D64_6174;

   typedef logic [7:0] byte_q_type [$];

   logic clock;
   logic reset;
   logic quiet;
   logic hold_rsp;
   int   errors;
   int   outstanding;
   int   beats_sent;

   mbhw_req_if req();
   mbhw_rsp_if rsp();

   mp4_box_header_walker #(.MAX_DEPTH(DEPTH)) i_dut (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp)
   );

   mbhw_checker #(.DEPTH(DEPTH)) i_checker (
      .clock(clock),
      .reset(reset),
      .req(req),
      .rsp(rsp),
      .errors(errors),
      .outstanding(outstanding)
   );

   always #5 clock = ~clock;

   function automatic byte_q_type joined(input byte_q_type a, input byte_q_type b);
      foreach (b[i]) a.push_back(b[i]);
      return a;
   endfunction

   function automatic byte_q_type box_bytes(input logic [31:0] size, input logic [31:0] kind,
                                            input byte_q_type body);
      byte_q_type q;
      for (int i = 3; i >= 0; i--) q.push_back(size[8*i +: 8]);
      for (int i = 3; i >= 0; i--) q.push_back(kind[8*i +: 8]);
      foreach (body[i]) q.push_back(body[i]);
      return q;
   endfunction

   function automatic byte_q_type noise_bytes(input int count);
      byte_q_type q;
      repeat (count) q.push_back(8'($urandom));
      return q;
   endfunction

   function automatic byte_q_type leaf_boxes(input int count);
      byte_q_type q;
      byte_q_type body;
      logic [31:0] kind;
      for (int n = 0; n < count; n++) begin
         body = noise_bytes($urandom_range(0, 8));
         case ($urandom_range(3))
            0: kind = TYPE_MDAT;
            1: kind = TYPE_FREE;
            default: kind = $urandom;
         endcase
         q = joined(q, box_bytes(32'(body.size() + 8), kind, body));
      end
      return q;
   endfunction

   // containers wrapped around leaves; skew makes declared sizes disagree with content
   function automatic byte_q_type nested_box(input bit skew);
      byte_q_type body;
      int levels;
      int delta;
      if ($urandom_range(9) == 0) levels = $urandom_range(DEPTH, DEPTH + 2);
      else levels = $urandom_range(1, 3);
      body = leaf_boxes($urandom_range(0, 3));
      for (int l = 0; l < levels; l++) begin
         delta = (skew && $urandom_range(2) == 0) ? int'($urandom_range(0, 12)) - 6 : 0;
         body = box_bytes(32'(body.size() + 8 + delta),
                          $urandom_range(1) ? TYPE_MOOF : TYPE_TRAF, body);
         if ($urandom_range(2) == 0) body = joined(body, leaf_boxes(1));
         if ($urandom_range(3) == 0) body = joined(leaf_boxes(1), body);
      end
      return body;
   endfunction

   function automatic byte_q_type top_boxes(input int count, input bit skew);
      byte_q_type q;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(2) == 0) q = joined(q, leaf_boxes(1));
         else q = joined(q, nested_box(skew));
      end
      return q;
   endfunction

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_beat(input logic [7:0] data, input logic eos);
      while (!quiet && $urandom_range(99) < 19) begin
         req.valid <= 1'b0;
         @(negedge clock);
      end
      req.valid <= 1'b1;
      req.data_byte <= data;
      req.end_of_stream <= eos;
      do @(posedge clock); while (!req.ready);
      beats_sent++;
      @(negedge clock);
   endtask

   // sends the first count bytes, end of stream on the last one sent
   task automatic send_bytes(input byte_q_type s, input int count);
      for (int i = 0; i < count; i++) send_beat(s[i], i == count - 1);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
   endtask

   task automatic random_stream();
      byte_q_type s;
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) begin
         s = top_boxes($urandom_range(1, 3), 1'b0);
         send_bytes(s, s.size());
      end else if (pick < 72) begin
         s = top_boxes($urandom_range(1, 3), 1'b0);
         send_bytes(s, $urandom_range(1, s.size()));
      end else if (pick < 82) begin
         s = top_boxes($urandom_range(0, 2), 1'b0);
         s = joined(s, box_bytes($urandom_range(0, 7), $urandom, noise_bytes($urandom_range(0, 6))));
         send_bytes(s, s.size());
      end else if (pick < 91) begin
         s = top_boxes($urandom_range(1, 3), 1'b1);
         send_bytes(s, s.size());
      end else begin
         s = noise_bytes($urandom_range(1, 24));
         send_bytes(s, s.size());
      end
   endtask

   initial begin : receiver
      rsp.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else begin
            rsp.ready <= quiet || $urandom_range(99) >= 19;
         end
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("tb: done, errors");
      $finish;
   end

   initial begin : stimulus
      byte_q_type s;
      byte_q_type body;
      byte_q_type none;
      int target;
      clock = 1'b0;
      reset = 1'b1;
      quiet = 1'b0;
      hold_rsp = 1'b0;
      beats_sent = 0;
      req.valid = 1'b0;
      req.data_byte = '0;
      req.end_of_stream = 1'b0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // empty leaf and empty container, both complete
      s = joined(box_bytes(32'd8, TYPE_FREE, none), box_bytes(32'd8, TYPE_MOOF, none));
      send_bytes(s, s.size());
      // size zero: bytes after it are ignored up to end of stream
      body = '{8'h00, 8'hFF, 8'h5A};
      s = box_bytes(32'd0, 32'hFFFF_FFFF, body);
      send_bytes(s, s.size());
      // size seven with end of stream on the last header byte
      s = box_bytes(32'd7, TYPE_MDAT, none);
      send_bytes(s, s.size());
      // header done on the final byte with content still due: box then truncation
      s = box_bytes(32'd12, TYPE_MDAT, noise_bytes(4));
      send_bytes(s, 8);
      // largest size, cut short
      body = '{8'hFF, 8'h00};
      s = box_bytes(32'hFFFF_FFFF, 32'h0000_0000, body);
      send_bytes(s, s.size());
      // stream ends inside a header
      s = noise_bytes(3);
      send_bytes(s, s.size());
      // containers past the depth limit: the innermost moof is skipped as a leaf
      s = box_bytes(32'd10, TYPE_FREE, noise_bytes(2));
      s = box_bytes(32'(s.size() + 8), TYPE_MOOF, s);
      for (int l = 0; l < 3; l++) s = box_bytes(32'(s.size() + 8), TYPE_TRAF, s);
      s = box_bytes(32'(s.size() + 8), TYPE_MOOF, s);
      send_bytes(s, s.size());
      // child longer than its parent: parent closes, the skip carries on
      s = box_bytes(32'd24, TYPE_FREE, noise_bytes(16));
      s = box_bytes(32'd20, TYPE_MOOF, s);
      send_bytes(s, s.size());
      // stream ends with a level still open
      s = box_bytes(32'd8, TYPE_FREE, none);
      s = box_bytes(32'd30, TYPE_TRAF, s);
      send_bytes(s, s.size());
      drain();

      // no idling on either side
      quiet = 1'b1;
      target = beats_sent + QUIET_BYTES;
      while (beats_sent < target) random_stream();
      quiet = 1'b0;
      drain();

      // rsp held off while a run of empty boxes fills the result queue
      hold_rsp = 1'b1;
      s = none;
      repeat (12) s = joined(s, box_bytes(32'd8, TYPE_FREE, none));
      send_bytes(s, s.size());
      drain();

      target = beats_sent + RANDOM_BYTES;
      while (beats_sent < target) begin
         random_stream();
         if ($urandom_range(7) == 0) drain();
      end
      drain();
      repeat (20) @(negedge clock);

      if (errors == 0 && outstanding == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
